FILE: rtl/assert_macros.svh
// Concurrent assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define BSB_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define BSB_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `BSB_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

FILE: rtl/bsb_pkg.sv
`default_nettype none

package bsb_pkg;

  localparam int unsigned SPEED_W    = 24;
  localparam int unsigned ACCEL_W    = 32;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned CIRC_W     = 16;
  localparam int unsigned DECEL_W    = 8;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned MODE_COUNT = 3;

  // Shared multiplier operand widths and the divider widths it feeds
  localparam int unsigned MUL_A_W   = 24;
  localparam int unsigned MUL_B_W   = 20;
  localparam int unsigned DIV_NUM_W = MUL_A_W + MUL_B_W;
  localparam int unsigned DIV_DEN_W = 32;

  // circumference * 3600 s/h * 256 (Q8) / 1e6 us/s expressed per us: C * 921600 / dt
  localparam logic [MUL_B_W-1:0] SPEED_SCALE = 20'd921600;
  // speed difference scaled from per-us to per-second
  localparam logic [MUL_B_W-1:0] ACCEL_SCALE = 20'd1000000;

  localparam logic [SPEED_W-1:0] SPEED_MAX = {SPEED_W{1'b1}};
  localparam logic [ACCEL_W-1:0] ACCEL_MAX = {1'b0, {(ACCEL_W-1){1'b1}}};
  localparam logic [ACCEL_W-1:0] ACCEL_MIN = {1'b1, {(ACCEL_W-1){1'b0}}};

endpackage

`default_nettype wire

FILE: rtl/bsb_divider.sv
`default_nettype none

// Radix-2 restoring divider, one quotient bit per cycle.
module bsb_divider (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic [bsb_pkg::DIV_NUM_W-1:0]  dividend_i,
  input  wire logic [bsb_pkg::DIV_DEN_W-1:0]  divisor_i,
  output logic                                busy_o,
  output logic                                done_o,
  output logic [bsb_pkg::DIV_NUM_W-1:0]       quotient_o
);

  localparam int unsigned NW = bsb_pkg::DIV_NUM_W;
  localparam int unsigned DW = bsb_pkg::DIV_DEN_W;
  localparam int unsigned CW = $clog2(NW + 1);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] rem_q, rem_d;
  logic [NW-1:0] quo_q;
  logic [DW-1:0] dvs_q;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          take;

  // Bring down the next dividend bit and try the subtraction
  assign trial = {rem_q, quo_q[NW-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign take  = !diff[DW];
  assign rem_d = take ? diff[DW-1:0] : trial[DW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[NW-2:0], take};
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

FILE: rtl/bike_signal_brake_controller_top.sv
// Bicycle turn-signal, speedometer and brake-lamp controller. Each request on the
// slave stream is one event sample (microsecond timestamp plus mode, left, right
// and hall flags) and yields exactly one result on the master stream with the
// mode, signal and lamp levels, speed (mph Q8), acceleration (mph/s Q8) and
// distance after that event. A sample without a hall pulse goes from S_IDLE to
// S_DONE, where the result is loaded into the output register as the block
// returns to S_IDLE and is ready again. A sample with a hall pulse steps through
// S_SPD_MUL, S_SPD_DIV, S_ACC_SUB, S_ACC_MUL, S_ACC_DIV, S_FIN and S_DONE: the
// speed and the acceleration each run one 44-bit division through the shared
// restoring divider at one quotient bit per cycle (started in the multiply state
// and picked up when the divider is done), plus the subtract and finish steps
// around them. With a zero time interval the divisions are skipped. The input
// is not ready while a sample is in progress; a finished result waits in the
// output register and does not block the next sample, but a sample that finishes
// while that register is still full holds until the result has been taken.
// Configuration writes go through the cfg port and must only be issued while the
// block is idle.
`default_nettype none
`include "assert_macros.svh"

module bike_signal_brake_controller_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write port
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  // event samples
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [31:0] now_us, [32] mode_press, [33] left_press, [34] right_press,
  // [35] hall_pulse, [39:36] zero
  input  wire logic [39:0] s_axis_tdata,
  // results
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [1:0] current_mode, [2] left_signal_on, [3] right_signal_on, [4] left_lamp,
  // [5] right_lamp, [6] brake_lamp, [30:7] speed_q8, [62:31] accel_q8,
  // [94:63] distance_umiles, [95] zero
  output logic [95:0]      m_axis_tdata
);

  localparam int unsigned SPEED_W = bsb_pkg::SPEED_W;
  localparam int unsigned ACCEL_W = bsb_pkg::ACCEL_W;
  localparam int unsigned TIME_W  = bsb_pkg::TIME_W;
  localparam int unsigned MODE_W  = bsb_pkg::MODE_W;
  localparam int unsigned NW      = bsb_pkg::DIV_NUM_W;

  typedef enum logic [1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_BLINK    = 2'd1,
    CFG_CIRC     = 2'd2,
    CFG_DECEL    = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SPD_MUL,
    S_SPD_DIV,
    S_ACC_SUB,
    S_ACC_MUL,
    S_ACC_DIV,
    S_FIN,
    S_DONE
  } state_e;

  // Configuration
  logic [TIME_W-1:0]           debounce_q;
  logic [TIME_W-1:0]           blink_q;
  logic [bsb_pkg::CIRC_W-1:0]  circ_q;
  logic [bsb_pkg::DECEL_W-1:0] decel_q;

  // Architectural state
  state_e             state_q;
  logic [MODE_W-1:0]  mode_q;
  logic               left_active_q, right_active_q;
  logic               left_lamp_q, right_lamp_q;
  logic               brake_q;
  logic [TIME_W-1:0]  last_accept_q, last_blink_q, last_rev_q;
  logic [SPEED_W-1:0] last_speed_q;
  logic [ACCEL_W-1:0] accel_q;
  logic [TIME_W-1:0]  distance_q;
  logic               m_valid_q;

  // Per-sample working registers
  logic [TIME_W-1:0]  dt_q;
  logic [SPEED_W-1:0] speed_q;
  logic [SPEED_W-1:0] mag_q;
  logic               neg_q;
  logic [94:0]        out_q;

  // Input fields
  logic [TIME_W-1:0] now_us;
  logic              mode_press, left_press, right_press, hall_pulse;
  assign now_us      = s_axis_tdata[31:0];
  assign mode_press  = s_axis_tdata[32];
  assign left_press  = s_axis_tdata[33];
  assign right_press = s_axis_tdata[34];
  assign hall_pulse  = s_axis_tdata[35];

  logic accept;
  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Buttons and blink. An accepted press stamps last_accept_q with now; within one
  // sample the buttons are taken in priority order, so only the first pressed
  // button in mode, left, right order can act.
  logic [TIME_W-1:0] since_press, since_blink;
  logic              press_ok, blink_due;
  logic [MODE_W-1:0] mode_d;
  logic              l_act_d, r_act_d, l_lamp_d, r_lamp_d, took_press;

  assign since_press = now_us - last_accept_q;
  assign since_blink = now_us - last_blink_q;
  assign press_ok    = since_press > debounce_q;
  assign blink_due   = since_blink >= blink_q;

  always_comb begin
    mode_d     = mode_q;
    l_act_d    = left_active_q;
    r_act_d    = right_active_q;
    l_lamp_d   = left_lamp_q;
    r_lamp_d   = right_lamp_q;
    took_press = 1'b0;
    if (press_ok) begin
      priority if (mode_press) begin
        took_press = 1'b1;
        mode_d     = (mode_q == MODE_W'(bsb_pkg::MODE_COUNT - 1)) ? '0
                                                                   : mode_q + MODE_W'(1);
      end else if (left_press) begin
        took_press = 1'b1;
        r_act_d    = 1'b0;
        r_lamp_d   = 1'b0;
        if (left_active_q) begin
          l_act_d  = 1'b0;
          l_lamp_d = 1'b0;
        end else begin
          l_act_d = 1'b1;
        end
      end else if (right_press) begin
        took_press = 1'b1;
        l_act_d    = 1'b0;
        l_lamp_d   = 1'b0;
        if (right_active_q) begin
          r_act_d  = 1'b0;
          r_lamp_d = 1'b0;
        end else begin
          r_act_d = 1'b1;
        end
      end else begin
        took_press = 1'b0;
      end
    end
    // Toggle the lamp of whichever signal is active
    if (blink_due) begin
      if (l_act_d) begin
        l_lamp_d = !l_lamp_d;
      end else if (r_act_d) begin
        r_lamp_d = !r_lamp_d;
      end
    end
  end

  // Shared multiplier: speed numerator first, then the scaled speed change
  logic [bsb_pkg::MUL_A_W-1:0] mul_a;
  logic [bsb_pkg::MUL_B_W-1:0] mul_b;
  logic [NW-1:0]               mul_p;
  assign mul_a = (state_q == S_SPD_MUL) ? bsb_pkg::MUL_A_W'(circ_q) : mag_q;
  assign mul_b = (state_q == S_SPD_MUL) ? bsb_pkg::SPEED_SCALE : bsb_pkg::ACCEL_SCALE;
  assign mul_p = {{bsb_pkg::MUL_B_W{1'b0}}, mul_a} * {{bsb_pkg::MUL_A_W{1'b0}}, mul_b};

  // Divider
  logic          div_start, div_busy, div_done, div_wait;
  logic [NW-1:0] div_quo;
  logic          dt_zero;
  assign dt_zero   = (dt_q == '0);
  assign div_start = ((state_q == S_SPD_MUL) || (state_q == S_ACC_MUL)) && !dt_zero;
  assign div_wait  = (state_q == S_SPD_DIV) || (state_q == S_ACC_DIV);

  bsb_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mul_p),
    .divisor_i  (dt_q),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Saturate the quotients
  logic [SPEED_W-1:0] speed_sat;
  logic [ACCEL_W-1:0] accel_sat;
  logic [ACCEL_W-1:0] accel_zero_dt;
  assign speed_sat = (|div_quo[NW-1:SPEED_W]) ? bsb_pkg::SPEED_MAX : div_quo[SPEED_W-1:0];

  always_comb begin
    if (neg_q) begin
      // Magnitude above 2^31 clips to the most negative value
      if ((|div_quo[NW-1:ACCEL_W]) || (div_quo[ACCEL_W-1] && (|div_quo[ACCEL_W-2:0]))) begin
        accel_sat = bsb_pkg::ACCEL_MIN;
      end else begin
        accel_sat = -div_quo[ACCEL_W-1:0];
      end
    end else begin
      accel_sat = (|div_quo[NW-1:ACCEL_W-1]) ? bsb_pkg::ACCEL_MAX : div_quo[ACCEL_W-1:0];
    end
  end

  assign accel_zero_dt = (mag_q == '0) ? '0 : (neg_q ? bsb_pkg::ACCEL_MIN : bsb_pkg::ACCEL_MAX);

  // Brake lights below minus threshold * 256
  logic signed [ACCEL_W-1:0] brake_lim;
  assign brake_lim = -$signed({{(ACCEL_W - bsb_pkg::DECEL_W - 8){1'b0}}, decel_q, 8'b0});

  logic out_free, out_load;
  assign out_free = !m_valid_q || m_axis_tready;
  assign out_load = (state_q == S_DONE) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q     <= 32'd300000;
      blink_q        <= 32'd500000;
      circ_q         <= 16'd1289;
      decel_q        <= 8'd1;
      state_q        <= S_IDLE;
      mode_q         <= '0;
      left_active_q  <= 1'b0;
      right_active_q <= 1'b0;
      left_lamp_q    <= 1'b0;
      right_lamp_q   <= 1'b0;
      brake_q        <= 1'b0;
      last_accept_q  <= '0;
      last_blink_q   <= '0;
      last_rev_q     <= '0;
      last_speed_q   <= '0;
      accel_q        <= '0;
      distance_q     <= '0;
      m_valid_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_DEBOUNCE: debounce_q <= cfg_data_i;
          CFG_BLINK:    blink_q    <= cfg_data_i;
          CFG_CIRC:     circ_q     <= cfg_data_i[bsb_pkg::CIRC_W-1:0];
          CFG_DECEL:    decel_q    <= cfg_data_i[bsb_pkg::DECEL_W-1:0];
        endcase
      end

      // Load a finished result, else drop the one just taken
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            mode_q         <= mode_d;
            left_active_q  <= l_act_d;
            right_active_q <= r_act_d;
            left_lamp_q    <= l_lamp_d;
            right_lamp_q   <= r_lamp_d;
            if (took_press) begin
              last_accept_q <= now_us;
            end
            if (blink_due) begin
              last_blink_q <= now_us;
            end
            if (hall_pulse) begin
              last_rev_q <= now_us;
              distance_q <= distance_q + TIME_W'(circ_q);
              state_q    <= S_SPD_MUL;
            end else begin
              state_q <= S_DONE;
            end
          end
        end
        S_SPD_MUL: begin
          state_q <= dt_zero ? S_ACC_SUB : S_SPD_DIV;
        end
        S_SPD_DIV: begin
          if (div_done) begin
            state_q <= S_ACC_SUB;
          end
        end
        S_ACC_SUB: begin
          state_q <= S_ACC_MUL;
        end
        S_ACC_MUL: begin
          if (dt_zero) begin
            accel_q <= accel_zero_dt;
            state_q <= S_FIN;
          end else begin
            state_q <= S_ACC_DIV;
          end
        end
        S_ACC_DIV: begin
          if (div_done) begin
            accel_q <= accel_sat;
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          brake_q      <= $signed(accel_q) < brake_lim;
          last_speed_q <= speed_q;
          state_q      <= S_DONE;
        end
        S_DONE: begin
          // Hold here until the output register can take the result
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Working registers and the result snapshot
  always_ff @(posedge clk_i) begin
    if (accept) begin
      dt_q <= now_us - last_rev_q;
    end
    if ((state_q == S_SPD_MUL) && dt_zero) begin
      speed_q <= bsb_pkg::SPEED_MAX;
    end else if ((state_q == S_SPD_DIV) && div_done) begin
      speed_q <= speed_sat;
    end
    if (state_q == S_ACC_SUB) begin
      neg_q <= speed_q < last_speed_q;
      mag_q <= (speed_q < last_speed_q) ? last_speed_q - speed_q : speed_q - last_speed_q;
    end
    if (out_load) begin
      out_q <= {distance_q, accel_q, last_speed_q, brake_q, right_lamp_q, left_lamp_q,
                right_active_q, left_active_q, mode_q};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {1'b0, out_q};

  `BSB_ASSERT_NEVER(a_signal_excl, clk_i, rst_ni, left_active_q && right_active_q, "both on")
  `BSB_ASSERT(a_mode_range, clk_i, rst_ni, {1'b0, mode_q} < 3'(bsb_pkg::MODE_COUNT), "mode range")
  `BSB_ASSERT(a_div_nonzero, clk_i, rst_ni, div_start |-> dt_q != '0, "divide by zero interval")
  `BSB_ASSERT(a_div_done_state, clk_i, rst_ni, div_done |-> div_wait, "divider done out of place")
  `BSB_ASSERT_NEVER(a_ready_busy, clk_i, rst_ni, s_axis_tready && div_busy, "ready while dividing")

endmodule

`default_nettype wire
